// ===== sv/lfu_pkg.sv =====
package lfu_pkg;

  // Fixed field widths of the ports and related constants
  localparam int CFG_W       = 4;
  localparam int CFG_RESET   = 8;
  localparam int IN_PAGE_W   = 8;
  localparam int FRAME_OUT_W = 3;
  localparam int PAGE_OUT_W  = 8;
  localparam int USE_OUT_W   = 16;
  localparam int HIT_W       = 16;
  localparam int STAMP_W     = 32;
  localparam int IN_CODES    = 256;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic act;   // frame index is below the resident count
    logic lim;   // frame index is below the frame limit
    logic upd;   // commit: refresh the cached count if the page matches
    logic ld;    // commit: load the new page into this cell
  } cell_cmd_t;

endpackage

// ===== sv/lfu_cell.sv =====
module lfu_cell import lfu_pkg::*; #(
  parameter int IDX    = 0,
  parameter int SLOT_W = 3,
  parameter int PG_W   = 8,
  parameter int CNT_W  = 16
) (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic [PG_W-1:0]    pg,
  input  logic [STAMP_W-1:0] nstamp,
  input  logic [CNT_W-1:0]   new_cnt,
  // token from the left neighbor
  input  logic               ti_found,
  input  logic [SLOT_W-1:0]  ti_hslot,
  input  logic [CNT_W-1:0]   ti_bcnt,
  input  logic [STAMP_W-1:0] ti_bage,
  input  logic [SLOT_W-1:0]  ti_bslot,
  input  logic [PG_W-1:0]    ti_bpage,
  // token to the right neighbor
  output logic               to_found,
  output logic [SLOT_W-1:0]  to_hslot,
  output logic [CNT_W-1:0]   to_bcnt,
  output logic [STAMP_W-1:0] to_bage,
  output logic [SLOT_W-1:0]  to_bslot,
  output logic [PG_W-1:0]    to_bpage
);

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

  // frame contents and cached use count of the resident page
  logic [PG_W-1:0]    page_r;
  logic [STAMP_W-1:0] stamp_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               found_r,  found_nxt;
  logic [SLOT_W-1:0]  hslot_r,  hslot_nxt;
  logic [CNT_W-1:0]   bcnt_r,   bcnt_nxt;
  logic [STAMP_W-1:0] bage_r,   bage_nxt;
  logic [SLOT_W-1:0]  bslot_r,  bslot_nxt;
  logic [PG_W-1:0]    bpage_r,  bpage_nxt;

  logic [STAMP_W-1:0] age;
  logic               take;

  // hit search and victim search on the passing token
  always_comb begin
    age       = nstamp - stamp_r;
    found_nxt = ti_found;
    hslot_nxt = ti_hslot;
    if (!ti_found && cmd.act && (page_r == pg)) begin
      found_nxt = 1'b1;
      hslot_nxt = MY_SLOT;
    end
    // lower count wins, ties go to the older (or equal age, later) frame
    take = cmd.lim && ((IDX == 0) || (cnt_r < ti_bcnt) ||
                       ((cnt_r == ti_bcnt) && (age >= ti_bage)));
    bcnt_nxt  = take ? cnt_r   : ti_bcnt;
    bage_nxt  = take ? age     : ti_bage;
    bslot_nxt = take ? MY_SLOT : ti_bslot;
    bpage_nxt = take ? page_r  : ti_bpage;
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    hslot_r <= hslot_nxt;
    bcnt_r  <= bcnt_nxt;
    bage_r  <= bage_nxt;
    bslot_r <= bslot_nxt;
    bpage_r <= bpage_nxt;
  end

  // frame load and count refresh at commit
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      page_r  <= pg;
      stamp_r <= nstamp;
      cnt_r   <= new_cnt;
    end else if (cmd.upd && (page_r == pg)) begin
      cnt_r <= new_cnt;
    end
  end

  assign to_found = found_r;
  assign to_hslot = hslot_r;
  assign to_bcnt  = bcnt_r;
  assign to_bage  = bage_r;
  assign to_bslot = bslot_r;
  assign to_bpage = bpage_r;

endmodule

// ===== sv/lfu_cnt_mem.sv =====
module lfu_cnt_mem import lfu_pkg::*; #(
  parameter int PAGES = 256,
  parameter int PG_W  = 8,
  parameter int CNT_W = 16
) (
  input  logic             clk,
  input  logic             we,
  input  logic [PG_W-1:0]  waddr,
  input  logic [CNT_W-1:0] wdata,
  input  logic             re,
  input  logic [PG_W-1:0]  raddr,
  output logic [CNT_W-1:0] rdata
);

  logic [CNT_W-1:0] mem [PAGES];
  logic [CNT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/lfu_page_frame_replacement.sv =====
// The result word is registered at commit, once the search token has left the last frame cell.
// A new word is taken only after the last one has committed; the search token walks the
//   row of frame cells one cell per cycle, so FRAMES sets the length of the search.
// Reset: synchronous, active low; afterwards a clearing pass over all PAGES addresses
//   zeroes the use-count memory while in_stall stays high.
module lfu_page_frame_replacement import lfu_pkg::*; #(
  parameter int FRAMES     = 8,
  parameter int PAGES      = 256,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [IN_PAGE_W-1:0]   in_page,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_hit,
  output logic [FRAME_OUT_W-1:0] out_frame,
  output logic                   out_evicted,
  output logic [PAGE_OUT_W-1:0]  out_evicted_page,
  output logic [USE_OUT_W-1:0]   out_use_count,
  output logic [HIT_W-1:0]       out_hit_total
);

  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int LIM_W  = $clog2(FRAMES + 1);
  localparam int PG_W   = $clog2(PAGES);
  localparam int CNT_W  = COUNT_BITS;
  localparam int CMP_W  = (LIM_W > CFG_W) ? LIM_W : CFG_W;
  localparam logic [CNT_W-1:0] CNT_MAX  = '1;
  localparam logic [HIT_W-1:0] HIT_MAX  = '1;
  localparam logic [PG_W-1:0]  LAST_PG  = PG_W'(PAGES - 1);
  localparam logic [LIM_W-1:0] LAST_CEL = LIM_W'(FRAMES - 1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   cfg_r;
  logic [LIM_W-1:0]   filled_r, filled_nxt;
  logic [STAMP_W-1:0] nstamp_r, nstamp_nxt;
  logic [HIT_W-1:0]   hits_r, hits_nxt;
  logic [PG_W-1:0]    pg_r;
  logic [PG_W-1:0]    clr_r, clr_nxt;
  logic [LIM_W-1:0]   scan_r, scan_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r;
  logic [FRAME_OUT_W-1:0] out_frame_r;
  logic                   out_evicted_r;
  logic [PAGE_OUT_W-1:0]  out_evicted_page_r;
  logic [USE_OUT_W-1:0]   out_use_count_r;
  logic [HIT_W-1:0]       out_hit_total_r;

  // input page reduced modulo PAGES through a constant table
  logic [PG_W-1:0] mod_tab [IN_CODES];
  logic [PG_W-1:0] pg_mod;

  for (genvar g = 0; g < IN_CODES; g++) begin : g_mod
    assign mod_tab[g] = PG_W'(g % PAGES);
  end
  assign pg_mod = mod_tab[in_page];

  // frame limit clamped to 1..FRAMES, resident count limited by it
  logic [CMP_W-1:0] cfg_x;
  logic [LIM_W-1:0] limit;
  logic [LIM_W-1:0] active;

  always_comb begin
    cfg_x = CMP_W'(cfg_r);
    if (cfg_x == '0) begin
      limit = LIM_W'(1);
    end else if (cfg_x > CMP_W'(FRAMES)) begin
      limit = LIM_W'(FRAMES);
    end else begin
      limit = LIM_W'(cfg_x);
    end
    active = (filled_r < limit) ? filled_r : limit;
  end

  // handshake
  logic accept;
  logic commit;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign commit   = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // use-count memory
  logic             mem_we;
  logic [PG_W-1:0]  mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [CNT_W-1:0] mem_rdata;
  logic [CNT_W-1:0] new_cnt;

  lfu_cnt_mem #(
    .PAGES (PAGES),
    .PG_W  (PG_W),
    .CNT_W (CNT_W)
  ) u_cnt_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (pg_mod),
    .rdata (mem_rdata)
  );

  // token chain through the frame cells; entry 0 is the fresh token
  logic               ch_found [FRAMES+1];
  logic [SLOT_W-1:0]  ch_hslot [FRAMES+1];
  logic [CNT_W-1:0]   ch_bcnt  [FRAMES+1];
  logic [STAMP_W-1:0] ch_bage  [FRAMES+1];
  logic [SLOT_W-1:0]  ch_bslot [FRAMES+1];
  logic [PG_W-1:0]    ch_bpage [FRAMES+1];

  assign ch_found[0] = 1'b0;
  assign ch_hslot[0] = '0;
  assign ch_bcnt[0]  = '0;
  assign ch_bage[0]  = '0;
  assign ch_bslot[0] = '0;
  assign ch_bpage[0] = '0;

  logic              do_load;
  logic [SLOT_W-1:0] ld_slot;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    cell_cmd_t cmd;

    assign cmd.act = (LIM_W'(g) < active);
    assign cmd.lim = (LIM_W'(g) < limit);
    assign cmd.upd = commit;
    assign cmd.ld  = commit && do_load && (ld_slot == SLOT_W'(g));

    lfu_cell #(
      .IDX    (g),
      .SLOT_W (SLOT_W),
      .PG_W   (PG_W),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .pg       (pg_r),
      .nstamp   (nstamp_r),
      .new_cnt  (new_cnt),
      .ti_found (ch_found[g]),
      .ti_hslot (ch_hslot[g]),
      .ti_bcnt  (ch_bcnt[g]),
      .ti_bage  (ch_bage[g]),
      .ti_bslot (ch_bslot[g]),
      .ti_bpage (ch_bpage[g]),
      .to_found (ch_found[g+1]),
      .to_hslot (ch_hslot[g+1]),
      .to_bcnt  (ch_bcnt[g+1]),
      .to_bage  (ch_bage[g+1]),
      .to_bslot (ch_bslot[g+1]),
      .to_bpage (ch_bpage[g+1])
    );
  end

  // commit decision from the token at the end of the row
  logic                    hit_w;
  logic                    ev_w;
  logic [SLOT_W-1:0]       slot_w;
  logic [PG_W-1:0]         ev_page_w;
  logic [CNT_W-1:0]        bumped;
  logic [SLOT_W+2:0]       slot_ext;
  logic [PG_W+7:0]         page_ext;
  logic [CNT_W+15:0]       cnt_ext;

  always_comb begin
    bumped    = (mem_rdata == CNT_MAX) ? CNT_MAX : mem_rdata + CNT_W'(1);
    hit_w     = ch_found[FRAMES];
    ev_w      = 1'b0;
    ev_page_w = '0;
    do_load   = 1'b0;
    if (hit_w) begin
      slot_w  = ch_hslot[FRAMES];
      new_cnt = bumped;
    end else if (filled_r < limit) begin
      slot_w  = SLOT_W'(filled_r);
      new_cnt = CNT_W'(1);
      do_load = 1'b1;
    end else begin
      slot_w    = ch_bslot[FRAMES];
      new_cnt   = bumped;
      do_load   = 1'b1;
      ev_w      = 1'b1;
      ev_page_w = ch_bpage[FRAMES];
    end
    ld_slot  = slot_w;
    slot_ext = {{3{1'b0}}, slot_w};
    page_ext = {{8{1'b0}}, ev_page_w};
    cnt_ext  = {{16{1'b0}}, new_cnt};
  end

  // memory write: clearing pass or count writeback
  always_comb begin
    mem_we    = (state_r == ST_CLEAR) || commit;
    mem_waddr = (state_r == ST_CLEAR) ? clr_r : pg_r;
    mem_wdata = (state_r == ST_CLEAR) ? '0 : new_cnt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    scan_nxt      = scan_r;
    filled_nxt    = filled_r;
    nstamp_nxt    = nstamp_r;
    hits_nxt      = hits_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + PG_W'(1);
        if (clr_r == LAST_PG) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        scan_nxt = '0;
        if (accept) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_nxt = scan_r + LIM_W'(1);
        if (scan_r == LAST_CEL) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (hit_w) begin
            if (hits_r != HIT_MAX) begin
              hits_nxt = hits_r + HIT_W'(1);
            end
          end else begin
            nstamp_nxt = nstamp_r + STAMP_W'(1);
            if (!ev_w) begin
              filled_nxt = filled_r + LIM_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cfg_r       <= CFG_W'(CFG_RESET);
      filled_r    <= '0;
      nstamp_r    <= '0;
      hits_r      <= '0;
      clr_r       <= '0;
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      nstamp_r    <= nstamp_nxt;
      hits_r      <= hits_nxt;
      clr_r       <= clr_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      pg_r <= pg_mod;
    end
    if (commit) begin
      out_hit_r          <= hit_w;
      out_frame_r        <= slot_ext[FRAME_OUT_W-1:0];
      out_evicted_r      <= ev_w;
      out_evicted_page_r <= page_ext[PAGE_OUT_W-1:0];
      out_use_count_r    <= cnt_ext[USE_OUT_W-1:0];
      out_hit_total_r    <= hits_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_frame        = out_frame_r;
  assign out_evicted      = out_evicted_r;
  assign out_evicted_page = out_evicted_page_r;
  assign out_use_count    = out_use_count_r;
  assign out_hit_total    = out_hit_total_r;

`ifndef SYNTHESIS
  a_rise_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result word appeared without a commit");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("hit and eviction reported together");

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_r <= LIM_W'(FRAMES))
    else $error("filled frame count beyond frame row");

  a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> in_stall)
    else $error("input taken during clearing pass");
`endif

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import lfu_pkg::*; ();

  localparam int FRAMES     = 8;
  localparam int PAGES      = 256;
  localparam int COUNT_BITS = 16;
  localparam int SETTLE     = FRAMES + 2;   // quiet span the driver needs before a limit write
  localparam int HOLD_AT    = 60;           // results before the long receiver hold
  localparam int LONG_HOLD  = 400;
  localparam int SAT_REFS   = 40;           // repeats of one page in the calm stretch
  localparam int CYCLE_CAP  = 4000000;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_PAGE,    // offer one page reference word
    OP_LIMIT,   // write the frame limit once the block is idle
    OP_PAUSE,   // hold the sender until every result has come back
    OP_CALM     // from here on neither side idles
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [IN_PAGE_W-1:0] page;
    logic [CFG_W-1:0]     limit;
  } op_t;

  typedef struct packed {
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame;
    logic                   evicted;
    logic [PAGE_OUT_W-1:0]  evicted_page;
    logic [USE_OUT_W-1:0]   use_count;
    logic [HIT_W-1:0]       hit_total;
  } lookup_t;

  // DUT connections, all inputs known from time zero
  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_W-1:0]       cfg_data = CFG_W'(CFG_RESET);
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [IN_PAGE_W-1:0]   in_page = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   out_hit;
  logic [FRAME_OUT_W-1:0] out_frame;
  logic                   out_evicted;
  logic [PAGE_OUT_W-1:0]  out_evicted_page;
  logic [USE_OUT_W-1:0]   out_use_count;
  logic [HIT_W-1:0]       out_hit_total;

  lfu_page_frame_replacement #(
    .FRAMES    (FRAMES),
    .PAGES     (PAGES),
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_page         (in_page),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_frame       (out_frame),
    .out_evicted     (out_evicted),
    .out_evicted_page(out_evicted_page),
    .out_use_count   (out_use_count),
    .out_hit_total   (out_hit_total)
  );

  always #10 clk = ~clk;

  // Stimulus and expected-result stores
  op_t     pending_ops[$];
  lookup_t expected_lookups[$];

  // Shadow of the replacement state
  logic [IN_PAGE_W-1:0]  held_page[FRAMES];
  logic [STAMP_W-1:0]    held_stamp[FRAMES];
  logic [COUNT_BITS-1:0] use_cnt[PAGES];
  logic [STAMP_W-1:0]    stamp_next = '0;
  logic [HIT_W-1:0]      hits = '0;
  int                    filled = 0;
  logic [CFG_W-1:0]      limit_reg = CFG_W'(CFG_RESET);

  int   mismatches = 0;
  int   results_seen = 0;
  int   cycles = 0;
  logic calm = 1'b0;
  logic send_idle_on = 1'b1;
  logic recv_idle_on = 1'b1;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? COUNT_MAX : c + 1'b1;
  endfunction

  // LFU lookup with oldest-load tie break; updates the shadow state
  function automatic lookup_t lfu_lookup(input logic [IN_PAGE_W-1:0] pg);
    lookup_t               r;
    int                    lim;
    int                    active;
    int                    slot;
    logic                  found;
    logic [COUNT_BITS-1:0] best_cnt;
    logic [COUNT_BITS-1:0] c;
    logic [STAMP_W-1:0]    best_age;
    logic [STAMP_W-1:0]    a;
    r = '0;
    found = 1'b0;
    slot = 0;
    lim = int'(limit_reg);
    if (lim < 1) lim = 1;
    if (lim > FRAMES) lim = FRAMES;
    active = (filled < lim) ? filled : lim;
    for (int i = 0; i < active; i++) begin
      if (!found && held_page[i] == pg) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      use_cnt[pg] = sat_inc(use_cnt[pg]);
      if (hits != '1) hits = hits + 1'b1;
    end else if (filled < lim) begin
      // free frame: load and start the count at one
      slot = filled;
      held_page[slot] = pg;
      held_stamp[slot] = stamp_next;
      stamp_next = stamp_next + 1'b1;
      use_cnt[pg] = 1;
      filled++;
    end else begin
      // lowest count wins, ties to the larger age, later index on equal age
      best_cnt = use_cnt[held_page[0]];
      best_age = stamp_next - held_stamp[0];
      for (int i = 1; i < lim; i++) begin
        c = use_cnt[held_page[i]];
        a = stamp_next - held_stamp[i];
        if (c < best_cnt || (c == best_cnt && a >= best_age)) begin
          best_cnt = c;
          best_age = a;
          slot = i;
        end
      end
      r.evicted = 1'b1;
      r.evicted_page = held_page[slot];
      held_page[slot] = pg;
      held_stamp[slot] = stamp_next;
      stamp_next = stamp_next + 1'b1;
      use_cnt[pg] = sat_inc(use_cnt[pg]);
    end
    r.frame = FRAME_OUT_W'(slot);
    r.use_count = USE_OUT_W'(use_cnt[pg]);
    r.hit_total = hits;
    return r;
  endfunction

  task automatic flag(input string msg);
    if (mismatches < 10) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want)
      flag($sformatf("%s expected %0h got %0h (result %0d)", name, want, got,
                     results_seen));
  endtask

  task automatic add_op(input op_t o);
    pending_ops = {pending_ops, o};
  endtask

  task automatic queue_ref(input logic [IN_PAGE_W-1:0] p);
    add_op('{kind: OP_PAGE, page: p, limit: '0});
  endtask

  task automatic queue_limit(input logic [CFG_W-1:0] v);
    add_op('{kind: OP_LIMIT, page: '0, limit: v});
  endtask

  task automatic queue_pause();
    add_op('{kind: OP_PAUSE, page: '0, limit: '0});
  endtask

  // Driver: offers words from the pending queue, writes the limit when idle
  int send_gap = 0;
  int quiet = 0;
  always @(posedge clk) begin : driver
    logic                 nv;
    logic [IN_PAGE_W-1:0] np;
    logic                 nwe;
    logic [CFG_W-1:0]     nd;
    logic                 ncalm;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nv = in_valid;
      np = in_page;
      nwe = 1'b0;
      nd = cfg_data;
      ncalm = calm;
      if (cycles % 128 == 0) send_idle_on = ($urandom_range(2) != 0);
      if (in_valid && !in_stall) begin
        expected_lookups = {expected_lookups, lfu_lookup(in_page)};
        void'(pending_ops.pop_front());
        nv = 1'b0;
        if (!calm && send_idle_on && $urandom_range(3) == 0)
          send_gap = $urandom_range(15, 1);
      end
      // idle means nothing in flight and the block ready for a word
      if (expected_lookups.size() == 0 && !in_valid && !in_stall) quiet++;
      else quiet = 0;
      if (!nv && pending_ops.size() > 0) begin
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          case (pending_ops[0].kind)
            OP_PAGE: begin
              nv = 1'b1;
              np = pending_ops[0].page;
            end
            OP_LIMIT: begin
              if (quiet >= SETTLE) begin
                nwe = 1'b1;
                nd = pending_ops[0].limit;
                limit_reg = pending_ops[0].limit;
                void'(pending_ops.pop_front());
                quiet = 0;
              end
            end
            OP_PAUSE: begin
              if (expected_lookups.size() == 0) void'(pending_ops.pop_front());
            end
            OP_CALM: begin
              ncalm = 1'b1;
              send_gap = 0;
              void'(pending_ops.pop_front());
            end
            default: ;
          endcase
        end
      end
      in_valid <= nv;
      in_page <= np;
      cfg_we <= nwe;
      cfg_data <= nd;
      calm <= ncalm;
    end
  end

  // Monitor: checks result words and drives the receiver stall
  int hold_left = 0;
  int stall_left = 0;
  logic hold_done = 1'b0;
  always @(posedge clk) begin : monitor
    logic    ns;
    lookup_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          flag($sformatf("result word with nothing expected (result %0d)", results_seen));
        end else begin
          want = expected_lookups.pop_front();
          check_field("hit", 16'(want.hit), 16'(out_hit));
          check_field("frame", 16'(want.frame), 16'(out_frame));
          check_field("evicted", 16'(want.evicted), 16'(out_evicted));
          check_field("evicted_page", 16'(want.evicted_page), 16'(out_evicted_page));
          check_field("use_count", want.use_count, out_use_count);
          check_field("hit_total", want.hit_total, out_hit_total);
        end
        results_seen++;
      end
      if (cycles % 128 == 64) recv_idle_on = ($urandom_range(2) != 0);
      ns = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        ns = 1'b1;
      end else if (results_seen == HOLD_AT && !hold_done) begin
        // long hold so the block backs up into its input
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        ns = 1'b1;
      end else if (!calm) begin
        if (stall_left > 0) begin
          stall_left--;
          ns = 1'b1;
        end else if (recv_idle_on && $urandom_range(4) == 0) begin
          stall_left = $urandom_range(15, 1) - 1;
          ns = 1'b1;
        end
      end
      out_stall <= ns;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [IN_PAGE_W-1:0] base;
    int                   ws;
    int                   n;
    foreach (use_cnt[i]) use_cnt[i] = '0;
    foreach (held_page[i]) held_page[i] = '0;
    foreach (held_stamp[i]) held_stamp[i] = '0;

    // Directed: extremes of the page, fill, hit, LFU eviction with a count tie
    queue_limit(4'd8);
    queue_ref(8'h00);
    queue_ref(8'hFF);
    queue_ref(8'h00);
    queue_ref(8'hAA);
    queue_ref(8'h55);
    queue_ref(8'h01);
    queue_ref(8'h02);
    queue_ref(8'h03);
    queue_ref(8'h04);
    queue_ref(8'h05);
    queue_ref(8'h06);
    queue_ref(8'hFF);
    // limit lowered below the filled frames: upper frames no longer resident
    queue_limit(4'd3);
    queue_ref(8'h04);
    queue_ref(8'h00);
    queue_ref(8'h07);
    // zero acts as one frame
    queue_limit(4'd0);
    queue_ref(8'h07);
    queue_ref(8'h08);
    // above the frame count acts as all frames
    queue_limit(4'd15);
    queue_ref(8'h02);
    queue_ref(8'h09);
    queue_ref(8'h0A);
    queue_pause();
    queue_ref(8'h02);

    // Random phases: skewed working sets with some noise pages
    for (int ph = 0; ph < 20; ph++) begin
      case (ph)
        0: queue_limit(4'd1);
        1: queue_limit(4'd8);
        2: queue_limit(4'd0);
        3: queue_limit(4'd15);
        default: queue_limit(4'($urandom_range(15)));
      endcase
      base = 8'($urandom_range(255));
      ws = $urandom_range(12, 2);
      n = $urandom_range(100, 60);
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && ph % 5 == 2) queue_pause();
        if ($urandom_range(9) < 8) begin
          if ($urandom_range(1) == 1)
            queue_ref(base + 8'($urandom_range(ws - 1) & $urandom_range(ws - 1)));
          else
            queue_ref(base + 8'($urandom_range(ws - 1)));
        end else begin
          queue_ref(8'($urandom_range(255)));
        end
      end
    end

    // Last stretch without idling: one hot page, then a single-frame swap
    queue_limit(4'd8);
    add_op('{kind: OP_CALM, page: '0, limit: '0});
    for (int k = 0; k < SAT_REFS; k++) queue_ref(8'h3C);
    queue_limit(4'd1);
    queue_ref(8'h3C);
    queue_ref(8'hC3);
    queue_ref(8'h3C);
    queue_ref(8'hC3);

    // Reset once, then let the driver and monitor run the queue
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_ops.size() != 0 || expected_lookups.size() != 0) @(posedge clk);
    repeat (4 * SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
